/* rtl/core/rect_gap_distance_defines.svh */
// Assertion shorthands shared by the rectangle gap block.
`ifndef RECT_GAP_DISTANCE_DEFINES_SVH
`define RECT_GAP_DISTANCE_DEFINES_SVH

// Check that expr holds at every clock edge out of reset.
`define RGD_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Check that cons holds in the same cycle whenever ante holds.
`define RGD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/rgd_pkg.sv */
package rgd_pkg;

    localparam int COORD_BITS_DEF = 15;
    localparam int FIELD_COUNT    = 8;
    localparam int GAP_BITS       = 17;
    localparam int OUT_TDATA_BITS = ((GAP_BITS + 7) / 8) * 8;

endpackage

/* rtl/core/rgd_prep.sv */
module rgd_prep
    import rgd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [COORD_BITS-1:0]     i_a_x,
    input  logic [COORD_BITS-1:0]     i_a_y,
    input  logic [COORD_BITS-1:0]     i_a_width,
    input  logic [COORD_BITS-1:0]     i_a_height,
    input  logic [COORD_BITS-1:0]     i_b_x,
    input  logic [COORD_BITS-1:0]     i_b_y,
    input  logic [COORD_BITS-1:0]     i_b_width,
    input  logic [COORD_BITS-1:0]     i_b_height,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [2*COORD_BITS+1:0]   o_sum
);

    localparam int C  = COORD_BITS;
    localparam int EW = C + 1;
    localparam int PW = 2 * C;
    localparam int SW = 2 * C + 2;
    localparam int NS = 4;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_adv;

    // stage 0: far edges
    logic [EW-1:0] r_ax, r_ay, r_axf, r_ayf, r_bx, r_by, r_bxf, r_byf;
    // stage 1: per-axis gaps
    logic [C-1:0]  r_dx, r_dy;
    // stage 2: squares
    logic [PW-1:0] r_dx2, r_dy2;
    // stage 3: squared distance
    logic [SW-1:0] r_sum;

    logic          w_left, w_right, w_below, w_above;
    logic [EW-1:0] w_gap_l, w_gap_r, w_gap_b, w_gap_a;
    logic [C-1:0]  n_dx, n_dy;
    logic [PW-1:0] n_dx2, n_dy2;

    // a stage moves on when it is empty or its successor takes its word
    always_comb begin
        w_adv[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = 0; k < NS - 1; k++) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[NS-1];
    assign o_sum   = r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // left and right exclude each other, as do below and above, so each axis
    // contributes one gap or none and the priority order collapses
    always_comb begin
        w_left  = r_bxf < r_ax;
        w_right = r_axf < r_bx;
        w_below = r_byf < r_ay;
        w_above = r_ayf < r_by;
        w_gap_l = r_ax - r_bxf;
        w_gap_r = r_bx - r_axf;
        w_gap_b = r_ay - r_byf;
        w_gap_a = r_by - r_ayf;
        n_dx    = '0;
        n_dy    = '0;
        if (w_left) begin
            n_dx = w_gap_l[C-1:0];
        end else if (w_right) begin
            n_dx = w_gap_r[C-1:0];
        end
        if (w_below) begin
            n_dy = w_gap_b[C-1:0];
        end else if (w_above) begin
            n_dy = w_gap_a[C-1:0];
        end
    end

    assign n_dx2 = PW'(r_dx) * PW'(r_dx);
    assign n_dy2 = PW'(r_dy) * PW'(r_dy);

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_ax  <= EW'(i_a_x);
            r_ay  <= EW'(i_a_y);
            r_bx  <= EW'(i_b_x);
            r_by  <= EW'(i_b_y);
            r_axf <= EW'(i_a_x) + EW'(i_a_width);
            r_ayf <= EW'(i_a_y) + EW'(i_a_height);
            r_bxf <= EW'(i_b_x) + EW'(i_b_width);
            r_byf <= EW'(i_b_y) + EW'(i_b_height);
        end
        if (w_adv[1]) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
        if (w_adv[2]) begin
            r_dx2 <= n_dx2;
            r_dy2 <= n_dy2;
        end
        if (w_adv[3]) begin
            r_sum <= SW'(r_dx2) + SW'(r_dy2);
        end
    end

endmodule

/* rtl/core/rgd_sqrt_cell.sv */
module rgd_sqrt_cell
    import rgd_pkg::*;
#(
    parameter int SW   = 2 * COORD_BITS_DEF + 2,
    parameter int STEP = COORD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [SW-1:0] i_rem,
    input  logic [SW-1:0] i_root,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [SW-1:0] o_rem,
    output logic [SW-1:0] o_root
);

    // weight of the root bit this cell decides, as a power of four
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * STEP);

    logic          r_valid;
    logic [SW-1:0] r_rem, r_root;
    logic [SW-1:0] w_try;
    logic [SW-1:0] n_rem, n_root;
    logic          w_adv;

    assign w_adv   = !r_valid || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;

    // restoring step: subtract the trial value when it fits
    always_comb begin
        w_try = i_root + BIT;
        if (i_rem >= w_try) begin
            n_rem  = i_rem - w_try;
            n_root = (i_root >> 1) + BIT;
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

endmodule

/* rtl/core/rect_gap_distance.sv */
// Gap between two axis-aligned rectangles. Each input word carries both
// rectangles as x, y, width and height; far edges are origin plus size and
// never wrap. The result is the floor of the Euclidean distance between the
// nearest corners when B lies diagonally off A, the plain edge gap when it
// lies off one side, and zero when the two touch or overlap. The block takes
// one rectangle pair every clock and hands back one result word per pair,
// in order. Four front stages form the far edges, the per-axis gaps, their
// squares and the squared distance, then a row of COORD_BITS + 1 square-root
// cells each settles one bit of the root. Every stage is a one-word register
// with its own valid, so bubbles close up and input is still taken while a
// finished result waits; input stalls only once every stage holds a word and
// the result is not being taken.
`include "rect_gap_distance_defines.svh"

module rect_gap_distance
    import rgd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // a_x, a_y, a_width, a_height, b_x, b_y, b_width, b_height (lowest first)
    input  logic [((FIELD_COUNT*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // gap_distance
    output logic [OUT_TDATA_BITS-1:0]     o_m_axis_tdata
);

    localparam int C  = COORD_BITS;
    localparam int SW = 2 * C + 2;
    localparam int NC = C + 1;

    logic [C-1:0]  w_field [FIELD_COUNT];
    logic          w_prep_valid, w_prep_ready;
    logic [SW-1:0] w_sum;

    // cell chain taps: index k feeds cell k, index NC is the last cell out
    logic          w_valid [NC+1];
    logic          w_ready [NC+1];
    logic [SW-1:0] w_rem   [NC+1];
    logic [SW-1:0] w_root  [NC+1];

    logic [SW+GAP_BITS-1:0] w_root_ext;

    // unpack the input word, first field in the low bits
    always_comb begin
        for (int f = 0; f < FIELD_COUNT; f++) begin
            w_field[f] = i_s_axis_tdata[f*C +: C];
        end
    end

    rgd_prep #(
        .COORD_BITS (COORD_BITS)
    ) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_a_x      (w_field[0]),
        .i_a_y      (w_field[1]),
        .i_a_width  (w_field[2]),
        .i_a_height (w_field[3]),
        .i_b_x      (w_field[4]),
        .i_b_y      (w_field[5]),
        .i_b_width  (w_field[6]),
        .i_b_height (w_field[7]),
        .o_valid    (w_prep_valid),
        .i_ready    (w_prep_ready),
        .o_sum      (w_sum)
    );

    // seed the root chain: whole square in the remainder, root cleared
    assign w_valid[0]   = w_prep_valid;
    assign w_prep_ready = w_ready[0];
    assign w_rem[0]     = w_sum;
    assign w_root[0]    = '0;

    // the squared distance stays below 2^(2C+1), so the root starts at 4^C
    for (genvar k = 0; k < NC; k++) begin : g_cell
        rgd_sqrt_cell #(
            .SW   (SW),
            .STEP (C - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_rem   (w_rem[k]),
            .i_root  (w_root[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_root  (w_root[k+1])
        );
    end

    // the last cell's register is the output register
    assign w_ready[NC]     = i_m_axis_tready;
    assign o_m_axis_tvalid = w_valid[NC];

    // drop root bits above the result width, pad the word with zeros
    assign w_root_ext     = (SW + GAP_BITS)'(w_root[NC]);
    assign o_m_axis_tdata = OUT_TDATA_BITS'(w_root_ext[GAP_BITS-1:0]);

    // the root is exact: remainder left over never exceeds twice the root
    `RGD_ASSERT_IMPLIES(a_root_exact, o_m_axis_tvalid, w_rem[NC] <= (w_root[NC] << 1), "square root remainder too large")
    // input stalls only when the whole chain is full and the result is held
    `RGD_ASSERT_IMPLIES(a_stall_cause, !o_s_axis_tready, o_m_axis_tvalid && !i_m_axis_tready, "input stalled without output back-pressure")
    // pad bits of the result word stay clear
    `RGD_ASSERT_ALWAYS(a_pad_zero, o_m_axis_tdata[OUT_TDATA_BITS-1:GAP_BITS] == '0, "result pad bits set")

endmodule
